### sv/iis_pkg.sv
// ----------------------------------------------------------------------------
// iis_pkg: shared types and constants of the streaming integral image block.
// Sizes of the line store and counters, register indexes and the position
// record passed from the raster counter to the datapath.
// ----------------------------------------------------------------------------
package iis_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DATA_W      = 32;
    localparam int DIM_W       = 11;
    localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    typedef logic [DATA_W-1:0] data_t;

    // Raster position of the item at the input.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             top_row;
        logic             last_col;
        logic             frame_end;
    } pos_t;

endpackage

### sv/iis_pixel_if.sv
// ----------------------------------------------------------------------------
// iis_pixel_if: pixel input channel.
// Valid/ready handshake carrying one pixel per item.
// ----------------------------------------------------------------------------
interface iis_pixel_if
    import iis_pkg::*;
;
    logic  valid;
    logic  ready;
    data_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

### sv/iis_result_if.sv
// ----------------------------------------------------------------------------
// iis_result_if: result output channel.
// Valid/ready handshake carrying one summed-area value per item.
// ----------------------------------------------------------------------------
interface iis_result_if
    import iis_pkg::*;
;
    logic  valid;
    logic  ready;
    data_t integral_sum;
    logic  frame_end;

    modport source (output valid, output integral_sum, output frame_end, input ready);
    modport sink   (input valid, input integral_sum, input frame_end, output ready);
endinterface

### sv/iis_ram.sv
// ----------------------------------------------------------------------------
// iis_ram: simple dual-port synchronous RAM.
// One write port and one read port; read data registered, old data returned
// when reading the entry written at the same edge.
// ----------------------------------------------------------------------------
module iis_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/iis_ctrl.sv
// ----------------------------------------------------------------------------
// iis_ctrl: configuration registers and raster counters.
// Holds image width and height, tracks column and row of the next item and
// flags the end of a row and of a frame.
// ----------------------------------------------------------------------------
module iis_ctrl
    import iis_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    input  logic                   accept,
    output pos_t                   pos
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [DIM_W:0]   col_plus;
    logic [DIM_W:0]   row_plus;
    logic             last_col;
    logic             last_row;

    // A zero dimension acts as one; oversized values saturate.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    assign width_eff  = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign height_eff = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));

    assign col_plus = (DIM_W+1)'(col_reg) + (DIM_W+1)'(1);
    assign row_plus = (DIM_W+1)'(row_reg) + (DIM_W+1)'(1);
    assign last_col = col_plus >= {1'b0, width_eff};
    assign last_row = row_plus >= {1'b0, height_eff};

    assign pos.col       = col_reg;
    assign pos.top_row   = (row_reg == '0);
    assign pos.last_col  = last_col;
    assign pos.frame_end = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_plus[ROW_W-1:0];
            end
            else
            begin
                col_next = col_plus[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

`ifndef SYNTHESIS
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_col |=> col_reg == '0)
        else $error("column counter did not wrap at end of row");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_col |=> col_reg == $past(col_reg) + COL_W'(1))
        else $error("column counter did not advance");

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_col |=> row_reg == $past(row_reg))
        else $error("row counter moved inside a row");
`endif

endmodule

### sv/integral_image_stream_core.sv
// ----------------------------------------------------------------------------
// integral_image_stream_core: streaming summed-area table, 32-bit unsigned.
// A pixel taken at the accept edge moves through the compute-stage register
// into the output register. Throughput: one item per cycle unless the output
// stalls, set by a single line-store read and write per pixel, with
// forwarding when consecutive items hit the same column.
// Reset clears counters, row accumulator and valid flags and loads 1024 into
// width and height; the line store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module integral_image_stream_core
    import iis_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    iis_pixel_if.sink              pixel_in,
    iis_result_if.source           result_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data
);

    // The pipeline has two stages. At the accept edge the pixel is added to the
    // row accumulator and the line store is read at the item's column. In the
    // compute stage the stored integral of the row above is added, and when the
    // pipe advances the new integral is written back to the same column while
    // the result moves into the output register. The whole pipe advances
    // whenever the output register is empty or being emptied, so an item is
    // taken every cycle while the downstream side keeps up.

    pos_t  pos;
    logic  pipe_en;
    logic  accept;
    data_t row_sum;
    data_t row_acc_reg;
    data_t ram_rdata;
    data_t above;
    data_t s1_sum;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_top_row_reg;
    logic             s1_frame_end_reg;
    data_t            s1_row_sum_reg;
    logic             s1_fwd_reg;
    data_t            s1_fwd_data_reg;
    logic             fwd_next;

    logic  out_valid_reg;
    data_t out_sum_reg;
    logic  out_frame_end_reg;

    assign pipe_en        = !out_valid_reg || result_out.ready;
    assign pixel_in.ready = pipe_en;
    assign accept         = pixel_in.valid && pipe_en;

    iis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pos       (pos)
    );

    assign row_sum = row_acc_reg + pixel_in.pixel;

    // When the previous item writes the very column this item reads at the
    // same edge, the memory returns the stale word, so the freshly computed
    // integral is captured alongside the item instead.
    assign fwd_next = s1_valid_reg && (s1_col_reg == pos.col);

    iis_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (DATA_W)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg && pipe_en),
        .waddr (s1_col_reg),
        .wdata (s1_sum),
        .re    (accept),
        .raddr (pos.col),
        .rdata (ram_rdata)
    );

    // Row zero sees nothing above it.
    assign above  = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign s1_sum = s1_row_sum_reg + (s1_top_row_reg ? '0 : above);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_acc_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_acc_reg <= pos.last_col ? '0 : row_sum;
            end
            if (pipe_en)
            begin
                s1_valid_reg  <= accept;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg       <= pos.col;
            s1_top_row_reg   <= pos.top_row;
            s1_frame_end_reg <= pos.frame_end;
            s1_row_sum_reg   <= row_sum;
            s1_fwd_reg       <= fwd_next;
            s1_fwd_data_reg  <= s1_sum;
        end
        if (pipe_en)
        begin
            out_sum_reg       <= s1_sum;
            out_frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.integral_sum = out_sum_reg;
    assign result_out.frame_end    = out_frame_end_reg;

`ifndef SYNTHESIS
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !pipe_en |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("stalled item left the compute stage");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && pipe_en |=> out_valid_reg)
        else $error("item dropped between compute stage and output register");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_out.ready |=> out_valid_reg
            && $stable(out_sum_reg) && $stable(out_frame_end_reg))
        else $error("waiting result item changed before it was taken");
`endif

endmodule
